### hdl/mat_pkg.sv
// Shared types and constants of the multi-ant turmite grid.
package mat_pkg;

  // Operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_CLEAR     = 3'd0,
    OP_WRITE     = 3'd1,
    OP_SET_ANT   = 3'd2,
    OP_SET_PAL   = 3'd3,
    OP_TICK      = 3'd4,
    OP_READ_CELL = 3'd5,
    OP_READ_ANT  = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_COLORS      = 3'd2,
    REG_TURN_RULE   = 3'd3,
    REG_ANTS        = 3'd4,
    REG_MARKER_EN   = 3'd5,
    REG_MARKER_RGB  = 3'd6,
    REG_OPAQUE      = 3'd7
  } reg_e;

  // Heading codes: north moves +y, east moves +x
  localparam logic [2:0] HEAD_N = 3'd1;
  localparam logic [2:0] HEAD_S = 3'd2;
  localparam logic [2:0] HEAD_W = 3'd3;
  localparam logic [2:0] HEAD_E = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam int unsigned RULE_BITS = 32;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  ant_index;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  value;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [31:0] start_tick;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [7:0] ant_x;
    logic [7:0] ant_y;
    logic [2:0] ant_heading;
  } out_item_t;

endpackage

### hdl/mat_ram.sv
// Generic single-port RAM with registered read data.
module mat_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write, and registered read; data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mat_step.sv
// Turn and move of one ant with wrap at the grid edges.
module mat_step #(
  parameter int CoordW = 8
) (
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  input  logic [CoordW:0]   w_i,
  input  logic [CoordW:0]   h_i,
  input  logic [2:0]        dir_i,
  input  logic              right_i,
  output logic [CoordW-1:0] x_o,
  output logic [CoordW-1:0] y_o,
  output logic [2:0]        dir_o
);
  import mat_pkg::*;

  typedef enum logic [1:0] {MV_XP, MV_XM, MV_YP, MV_YM} move_e;

  move_e         mv;
  logic [CoordW:0] xp1;
  logic [CoordW:0] yp1;

  // Pick the move and new heading from the heading and the turn direction
  always_comb begin
    unique case (dir_i)
      HEAD_N: begin
        mv    = right_i ? MV_XP : MV_XM;
        dir_o = right_i ? HEAD_E : HEAD_W;
      end
      HEAD_S: begin
        mv    = right_i ? MV_XM : MV_XP;
        dir_o = right_i ? HEAD_W : HEAD_E;
      end
      HEAD_W: begin
        mv    = right_i ? MV_YP : MV_YM;
        dir_o = right_i ? HEAD_N : HEAD_S;
      end
      default: begin
        mv    = right_i ? MV_YM : MV_YP;
        dir_o = right_i ? HEAD_S : HEAD_N;
      end
    endcase
  end

  assign xp1 = {1'b0, x_i} + 1'b1;
  assign yp1 = {1'b0, y_i} + 1'b1;

  // Move one cell and wrap
  always_comb begin
    x_o = x_i;
    y_o = y_i;
    unique case (mv)
      MV_XP: x_o = (xp1 >= w_i) ? '0 : xp1[CoordW-1:0];
      MV_XM: x_o = (x_i == '0) ? CoordW'(w_i - 1'b1) : x_i - 1'b1;
      MV_YP: y_o = (yp1 >= h_i) ? '0 : yp1[CoordW-1:0];
      MV_YM: y_o = (y_i == '0) ? CoordW'(h_i - 1'b1) : y_i - 1'b1;
      default: ;
    endcase
  end

endmodule

### hdl/multi_ant_turmite_grid.sv
// Multi-ant multicolor turmite grid: top level with sequencer and memories.
//
// Cell states and cell colors live in two single-port RAMs, palettes in a third.
// After reset and after a clear operation the block sweeps all
// 2**(2*clog2(GRID_SIDE)) cells of the state RAM (65536 at the default size),
// one cell per cycle, and stalls input meanwhile. A tick walks the ants in
// order; a stepping ant goes through state read, palette read and write back.
// Input stalls while an operation is handled; a read result sits in an
// output register until transferred.
module multi_ant_turmite_grid #(
  parameter int MAX_ANTS   = 8,
  parameter int MAX_COLORS = 32,
  parameter int GRID_SIDE  = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mat_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mat_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i
);
  import mat_pkg::*;

  localparam int CW     = $clog2(GRID_SIDE);
  localparam int WW     = CW + 1;
  localparam int CAW    = 2 * CW;
  localparam int CDEPTH = 1 << CAW;
  localparam int AW     = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;
  localparam int NW     = $clog2(MAX_ANTS + 1);
  localparam int CLW    = $clog2(MAX_COLORS + 1);
  localparam int PDEPTH = MAX_ANTS * MAX_COLORS;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DISP, S_ANT, S_RD, S_PAL, S_RDC, S_RDA
  } state_e;

  function automatic logic [CW-1:0] clampc(input logic [31:0] v, input logic [WW-1:0] lim);
    logic [CW-1:0] r;
    r = (v >= 32'(lim)) ? CW'(lim - 1'b1) : CW'(v);
    return r;
  endfunction

  // Configuration registers
  logic [8:0]  gw_q, gh_q;
  logic [5:0]  colors_q;
  logic [31:0] rule_q;
  logic [3:0]  ants_q;
  logic        mark_en_q;
  logic [23:0] mark_rgb_q;
  logic        opaque_q;

  // Sequencer and ant state
  state_e            state_q;
  in_item_t          item_q;
  logic [CAW-1:0]    clr_cnt_q;
  logic [NW-1:0]     ai_q;
  logic [31:0]       tick_q;
  logic [CW-1:0]     cx_q, cy_q;
  logic [7:0]        ns_q;
  logic              right_q;
  logic [CW-1:0]     ant_col_q   [MAX_ANTS];
  logic [CW-1:0]     ant_row_q   [MAX_ANTS];
  logic [2:0]        ant_dir_q   [MAX_ANTS];
  logic [31:0]       ant_start_q [MAX_ANTS];
  logic              out_valid_q;
  out_item_t         out_q;

  // Derived values
  logic [WW-1:0]  w_eff, h_eff;
  logic [NW-1:0]  n_eff;
  logic [CLW-1:0] cols_eff;
  logic [CW-1:0]  px, py, ax, ay, nx, ny;
  logic [2:0]     nd;
  logic [AW-1:0]  ai, ia;
  logic           ia_ok;
  logic [7:0]     st_rdata;
  logic [23:0]    col_rdata, pal_rdata;
  logic           s_ok, s_right;
  logic [8:0]     s_inc;
  logic           mark_hit;
  logic           slot_free;
  logic           load_out;
  out_item_t      out_d;

  // Memory ports
  logic           st_we, st_re, col_we, col_re, pal_we, pal_re;
  logic [CAW-1:0] st_addr, col_addr;
  logic [PAW-1:0] pal_addr;
  logic [7:0]     st_wdata;
  logic [23:0]    col_wdata;

  // Clamp the configuration to usable ranges
  always_comb begin
    w_eff = (gw_q == '0) ? WW'(1) : ((32'(gw_q) > GRID_SIDE) ? WW'(GRID_SIDE) : WW'(gw_q));
    h_eff = (gh_q == '0) ? WW'(1) : ((32'(gh_q) > GRID_SIDE) ? WW'(GRID_SIDE) : WW'(gh_q));
    n_eff = (32'(ants_q) > MAX_ANTS) ? NW'(MAX_ANTS) : NW'(ants_q);
    cols_eff = (32'(colors_q) > MAX_COLORS) ? CLW'(MAX_COLORS) : CLW'(colors_q);
  end

  assign px    = clampc(32'(item_q.pos_x), w_eff);
  assign py    = clampc(32'(item_q.pos_y), h_eff);
  assign ai    = ai_q[AW-1:0];
  assign ia    = AW'(item_q.ant_index);
  assign ia_ok = 32'(item_q.ant_index) < MAX_ANTS;
  assign ax    = clampc(32'(ant_col_q[ai]), w_eff);
  assign ay    = clampc(32'(ant_row_q[ai]), h_eff);

  // Decode the cell state read for the current ant
  assign s_ok    = 32'(st_rdata) < 32'(cols_eff);
  assign s_right = (32'(st_rdata) < RULE_BITS) && rule_q[st_rdata[4:0]];
  assign s_inc   = {1'b0, st_rdata} + 1'b1;

  // Check every active ant for a marker hit on the read cell
  always_comb begin
    mark_hit = 1'b0;
    for (int i = 0; i < MAX_ANTS; i++) begin
      if ((i < 32'(n_eff)) && (clampc(32'(ant_col_q[i]), w_eff) == px) &&
          (clampc(32'(ant_row_q[i]), h_eff) == py)) begin
        mark_hit = 1'b1;
      end
    end
  end

  // Drive the memory ports from the sequencer state
  always_comb begin
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_addr   = {py, px};
    st_wdata  = item_q.value;
    col_we    = 1'b0;
    col_re    = 1'b0;
    col_addr  = {py, px};
    col_wdata = {item_q.red_in, item_q.green_in, item_q.blue_in};
    pal_we    = 1'b0;
    pal_re    = 1'b0;
    pal_addr  = PAW'(int'(ia) * MAX_COLORS + int'(item_q.value));
    unique case (state_q)
      S_CLR: begin
        st_we    = 1'b1;
        st_addr  = clr_cnt_q;
        st_wdata = '0;
      end
      S_DISP: begin
        unique case (op_e'(item_q.operation))
          OP_WRITE: begin
            st_we  = 1'b1;
            col_we = 1'b1;
          end
          OP_SET_PAL: pal_we = ia_ok && (32'(item_q.value) < MAX_COLORS);
          OP_READ_CELL: begin
            st_re  = 1'b1;
            col_re = 1'b1;
          end
          default: ;
        endcase
      end
      S_ANT: begin
        st_re   = (ai_q < n_eff) && (tick_q > ant_start_q[ai]);
        st_addr = {ay, ax};
      end
      S_RD: begin
        pal_re   = s_ok;
        pal_addr = PAW'(int'(ai) * MAX_COLORS + int'(st_rdata));
      end
      S_PAL: begin
        st_we     = 1'b1;
        st_addr   = {cy_q, cx_q};
        st_wdata  = ns_q;
        col_we    = 1'b1;
        col_addr  = {cy_q, cx_q};
        col_wdata = pal_rdata;
      end
      default: ;
    endcase
  end

  mat_ram #(.Width(8), .Depth(CDEPTH)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .re_i    (st_re),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  mat_ram #(.Width(24), .Depth(CDEPTH)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .re_i    (col_re),
    .addr_i  (col_addr),
    .wdata_i (col_wdata),
    .rdata_o (col_rdata)
  );

  mat_ram #(.Width(24), .Depth(PDEPTH)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .re_i    (pal_re),
    .addr_i  (pal_addr),
    .wdata_i (col_wdata),
    .rdata_o (pal_rdata)
  );

  mat_step #(.CoordW(CW)) u_step (
    .x_i     (cx_q),
    .y_i     (cy_q),
    .w_i     (w_eff),
    .h_i     (h_eff),
    .dir_i   (ant_dir_q[ai]),
    .right_i (right_q),
    .x_o     (nx),
    .y_o     (ny),
    .dir_o   (nd)
  );

  // Form the read result
  assign slot_free = !out_valid_q || !out_stall_i;
  always_comb begin
    out_d    = '0;
    load_out = 1'b0;
    if (state_q == S_RDC) begin
      load_out = slot_free;
      {out_d.red_out, out_d.green_out, out_d.blue_out} =
        (mark_en_q && mark_hit) ? mark_rgb_q : col_rdata;
      out_d.alpha_out = opaque_q ? ALPHA_OPAQUE : st_rdata;
    end else if (state_q == S_RDA) begin
      load_out = slot_free;
      if (ia_ok) begin
        out_d.ant_x       = 8'(ant_col_q[ia]);
        out_d.ant_y       = 8'(ant_row_q[ia]);
        out_d.ant_heading = ant_dir_q[ia];
      end
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q       <= 9'd256;
      gh_q       <= 9'd256;
      colors_q   <= 6'd2;
      rule_q     <= 32'd1;
      ants_q     <= 4'd1;
      mark_en_q  <= 1'b1;
      mark_rgb_q <= '0;
      opaque_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:  gw_q       <= cfg_wdata_i[8:0];
        REG_GRID_HEIGHT: gh_q       <= cfg_wdata_i[8:0];
        REG_COLORS:      colors_q   <= cfg_wdata_i[5:0];
        REG_TURN_RULE:   rule_q     <= cfg_wdata_i;
        REG_ANTS:        ants_q     <= cfg_wdata_i[3:0];
        REG_MARKER_EN:   mark_en_q  <= cfg_wdata_i[0];
        REG_MARKER_RGB:  mark_rgb_q <= cfg_wdata_i[23:0];
        REG_OPAQUE:      opaque_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequence operations, ant walk and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      ai_q        <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ANTS; i++) begin
        ant_col_q[i]   <= '0;
        ant_row_q[i]   <= '0;
        ant_dir_q[i]   <= HEAD_N;
        ant_start_q[i] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == {CAW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          state_q <= S_IDLE;
          unique case (op_e'(item_q.operation))
            OP_CLEAR: begin
              clr_cnt_q <= '0;
              state_q   <= S_CLR;
            end
            OP_SET_ANT: begin
              if (ia_ok) begin
                ant_col_q[ia]   <= px;
                ant_row_q[ia]   <= py;
                ant_dir_q[ia]   <= (item_q.value >= 8'd1 && item_q.value <= 8'd4) ?
                                   item_q.value[2:0] : HEAD_E;
                ant_start_q[ia] <= item_q.start_tick;
              end
            end
            OP_TICK: begin
              if (tick_q != '1) begin
                tick_q <= tick_q + 1'b1;
              end
              ai_q    <= '0;
              state_q <= S_ANT;
            end
            OP_READ_CELL: state_q <= S_RDC;
            OP_READ_ANT:  state_q <= S_RDA;
            default: ;
          endcase
        end
        S_ANT: begin
          if (ai_q >= n_eff) begin
            state_q <= S_IDLE;
          end else if (tick_q > ant_start_q[ai]) begin
            cx_q    <= ax;
            cy_q    <= ay;
            state_q <= S_RD;
          end else begin
            ai_q <= ai_q + 1'b1;
          end
        end
        S_RD: begin
          right_q <= s_right;
          ns_q    <= (s_inc >= 9'(cols_eff)) ? 8'd0 : s_inc[7:0];
          if (s_ok) begin
            state_q <= S_PAL;
          end else begin
            // Out-of-cycle state: store the clamped position and stay put
            ant_col_q[ai] <= cx_q;
            ant_row_q[ai] <= cy_q;
            ai_q          <= ai_q + 1'b1;
            state_q       <= S_ANT;
          end
        end
        S_PAL: begin
          ant_col_q[ai] <= nx;
          ant_row_q[ai] <= ny;
          ant_dir_q[ai] <= nd;
          ai_q          <= ai_q + 1'b1;
          state_q       <= S_ANT;
        end
        S_RDC, S_RDA: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Input is stalled throughout the clearing sweep
  a_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> in_stall_o) else $error("input taken during clear sweep");

  // A transfer in always goes to dispatch next
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DISP)) else $error("transfer not dispatched");

  // The ant walk counter never passes the ant count
  a_ai_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ANT || state_q == S_RD || state_q == S_PAL) |-> (32'(ai_q) <= MAX_ANTS))
    else $error("ant counter out of range");

  // A step write back follows a palette read
  a_pal_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAL) |-> $past(pal_re)) else $error("write back without palette read");

endmodule

### bench/tb.sv
// Self-checking testbench for the multi-ant turmite grid.
`timescale 1ns / 1ps

module tb;
  import mat_pkg::*;

  localparam int SIDE        = 256;
  localparam int ANTS        = 8;
  localparam int COLORS      = 32;
  localparam int IDLE_LIMIT  = 200000;
  localparam int SETTLE_WAIT = 40;
  localparam int PHASE_ITEMS = 60;

  // Move codes used by the step rule
  localparam int MV_XP = 0;
  localparam int MV_XM = 1;
  localparam int MV_YP = 2;
  localparam int MV_YM = 3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  multi_ant_turmite_grid dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the grid, ants and registers
  logic [7:0]  grid_state [SIDE*SIDE];
  logic [23:0] grid_color [SIDE*SIDE];
  bit          color_known [SIDE*SIDE];
  logic [7:0]  ant_px [ANTS];
  logic [7:0]  ant_py [ANTS];
  logic [2:0]  ant_head [ANTS];
  logic [31:0] ant_wake [ANTS];
  logic [23:0] ant_palette [ANTS*COLORS];
  logic [31:0] tick_total;

  logic [8:0]  cfg_width;
  logic [8:0]  cfg_height;
  logic [5:0]  cfg_colors;
  logic [31:0] cfg_rule;
  logic [3:0]  cfg_ants;
  logic        cfg_marker_en;
  logic [23:0] cfg_marker_rgb;
  logic        cfg_opaque;

  out_item_t   read_results [$];
  int          fail_count;
  int          idle_cycles;
  bit          no_gaps;
  int          burst_left;
  bit          hold_request;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned width_used();
    if (cfg_width < 1) return 1;
    if (cfg_width > SIDE) return SIDE;
    return cfg_width;
  endfunction

  function automatic int unsigned height_used();
    if (cfg_height < 1) return 1;
    if (cfg_height > SIDE) return SIDE;
    return cfg_height;
  endfunction

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  function automatic int unsigned ants_active();
    return (cfg_ants > ANTS) ? ANTS : cfg_ants;
  endfunction

  // Walk one ant one step
  task automatic step_turmite(int unsigned a);
    int unsigned w, h, cols, x, y, s, ns, spot, mv;
    logic [2:0] d;
    bit right;
    w = width_used();
    h = height_used();
    cols = (cfg_colors > COLORS) ? COLORS : cfg_colors;
    x = clamp_to(ant_px[a], w);
    y = clamp_to(ant_py[a], h);
    d = ant_head[a];
    spot = y * SIDE + x;
    s = grid_state[spot];
    if (s < cols) begin
      right = (s < RULE_BITS) && cfg_rule[s];
      ns = (s + 1 >= cols) ? 0 : s + 1;
      grid_color[spot] = ant_palette[a*COLORS + s];
      color_known[spot] = 1'b1;
      grid_state[spot] = ns[7:0];
      if (right) begin
        case (d)
          HEAD_N:  begin mv = MV_XP; d = HEAD_E; end
          HEAD_S:  begin mv = MV_XM; d = HEAD_W; end
          HEAD_W:  begin mv = MV_YP; d = HEAD_N; end
          default: begin mv = MV_YM; d = HEAD_S; end
        endcase
      end else begin
        case (d)
          HEAD_N:  begin mv = MV_XM; d = HEAD_W; end
          HEAD_S:  begin mv = MV_XP; d = HEAD_E; end
          HEAD_W:  begin mv = MV_YM; d = HEAD_S; end
          default: begin mv = MV_YP; d = HEAD_N; end
        endcase
      end
      case (mv)
        MV_XP:   x = (x + 1 >= w) ? 0 : x + 1;
        MV_XM:   x = (x == 0) ? w - 1 : x - 1;
        MV_YP:   y = (y + 1 >= h) ? 0 : y + 1;
        default: y = (y == 0) ? h - 1 : y - 1;
      endcase
    end
    ant_px[a] = x[7:0];
    ant_py[a] = y[7:0];
    ant_head[a] = d;
  endtask

  // Apply one transferred item to the shadow copy, queue any read result
  task automatic apply_turmite(in_item_t it);
    int unsigned w, h, px, py, spot;
    logic [23:0] rgb, shown;
    out_item_t r;
    w = width_used();
    h = height_used();
    px = clamp_to(it.pos_x, w);
    py = clamp_to(it.pos_y, h);
    spot = py * SIDE + px;
    rgb = {it.red_in, it.green_in, it.blue_in};
    r = '0;
    case (op_e'(it.operation))
      OP_CLEAR: for (int c = 0; c < SIDE*SIDE; c++) grid_state[c] = '0;
      OP_WRITE: begin
        grid_state[spot] = it.value;
        grid_color[spot] = rgb;
        color_known[spot] = 1'b1;
      end
      OP_SET_ANT: begin
        ant_px[it.ant_index] = px[7:0];
        ant_py[it.ant_index] = py[7:0];
        ant_head[it.ant_index] = (it.value >= 1 && it.value <= 4) ? it.value[2:0] : HEAD_E;
        ant_wake[it.ant_index] = it.start_tick;
      end
      OP_SET_PAL: begin
        if (it.value < COLORS) ant_palette[it.ant_index*COLORS + it.value] = rgb;
      end
      OP_TICK: begin
        if (tick_total != 32'hFFFF_FFFF) tick_total++;
        for (int unsigned a = 0; a < ants_active(); a++)
          if (tick_total > ant_wake[a]) step_turmite(a);
      end
      OP_READ_CELL: begin
        shown = grid_color[spot];
        if (cfg_marker_en)
          for (int unsigned a = 0; a < ants_active(); a++)
            if (clamp_to(ant_px[a], w) == px && clamp_to(ant_py[a], h) == py)
              shown = cfg_marker_rgb;
        r.red_out = shown[23:16];
        r.green_out = shown[15:8];
        r.blue_out = shown[7:0];
        r.alpha_out = cfg_opaque ? ALPHA_OPAQUE : grid_state[spot];
        read_results.push_back(r);
      end
      OP_READ_ANT: begin
        r.ant_x = ant_px[it.ant_index];
        r.ant_y = ant_py[it.ant_index];
        r.ant_heading = ant_head[it.ant_index];
        read_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Offer one item, with bursts and gaps, and hold it until transferred
  task automatic send_item(in_item_t it);
    int gap;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_turmite(it);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(op_e op, int unsigned ai, int unsigned x,
                                         int unsigned y, int unsigned v,
                                         logic [23:0] rgb, logic [31:0] st);
    in_item_t it;
    it.operation = op;
    it.ant_index = ai[2:0];
    it.pos_x = x[7:0];
    it.pos_y = y[7:0];
    it.value = v[7:0];
    {it.red_in, it.green_in, it.blue_in} = rgb;
    it.start_tick = st;
    return it;
  endfunction

  // Read a cell, writing its color first if it was never written
  task automatic read_cell(int unsigned x, int unsigned y);
    int unsigned spot;
    spot = clamp_to(y, height_used()) * SIDE + clamp_to(x, width_used());
    if (!color_known[spot])
      send_item(make_item(OP_WRITE, $urandom_range(0, 7), x, y, $urandom_range(0, 255),
                          $urandom, $urandom));
    send_item(make_item(OP_READ_CELL, $urandom_range(0, 7), x, y, $urandom_range(0, 255),
                        $urandom, $urandom));
  endtask

  // Bring the block to idle: a read pushes through any sweep, then drain
  task automatic settle();
    send_item(make_item(OP_READ_ANT, 0, 0, 0, 0, '0, '0));
    stop_sending();
    wait (read_results.size() == 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  cfg_width = data[8:0];
      REG_GRID_HEIGHT: cfg_height = data[8:0];
      REG_COLORS:      cfg_colors = data[5:0];
      REG_TURN_RULE:   cfg_rule = data;
      REG_ANTS:        cfg_ants = data[3:0];
      REG_MARKER_EN:   cfg_marker_en = data[0];
      REG_MARKER_RGB:  cfg_marker_rgb = data[23:0];
      default:         cfg_opaque = data[0];
    endcase
  endtask

  task automatic write_setting(int w, int h, int cols, logic [31:0] rule, int ants,
                               bit mark, logic [23:0] rgb, bit opaque);
    write_reg(REG_GRID_WIDTH, 32'(w));
    write_reg(REG_GRID_HEIGHT, 32'(h));
    write_reg(REG_COLORS, 32'(cols));
    write_reg(REG_TURN_RULE, rule);
    write_reg(REG_ANTS, 32'(ants));
    write_reg(REG_MARKER_EN, 32'(mark));
    write_reg(REG_MARKER_RGB, 32'(rgb));
    write_reg(REG_OPAQUE, 32'(opaque));
  endtask

  // Fill every palette entry so ant painting never reads an unwritten entry
  task automatic test_palette_fill();
    for (int a = 0; a < ANTS; a++)
      for (int c = 0; c < COLORS; c++)
        send_item(make_item(OP_SET_PAL, a, $urandom_range(0, 255), $urandom_range(0, 255),
                            c, $urandom, $urandom));
  endtask

  // Field extremes, every operation and the corner cases
  task automatic test_directed();
    send_item(make_item(OP_WRITE, 0, 0, 0, 0, 24'h000000, 32'h0));
    send_item(make_item(OP_WRITE, 7, 255, 255, 255, 24'hFFFFFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_READ_CELL, 0, 255, 255, 0, '0, '0));
    send_item(make_item(OP_SET_PAL, 3, 0, 0, 200, 24'hABCDEF, '0));
    send_item(make_item(OP_SET_ANT, 0, 10, 10, 1, '0, 32'h0));
    send_item(make_item(OP_SET_ANT, 7, 255, 0, 0, '0, 32'hFFFF_FFFF));
    for (int hd = 2; hd <= 4; hd++)
      send_item(make_item(OP_SET_ANT, hd, 20 * hd, 5, hd, '0, hd));
    send_item(make_item(OP_READ_ANT, 7, 0, 0, 0, '0, '0));
    send_item(make_item(OP_READ_ANT, 0, 0, 0, 0, '0, '0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, '0, '0));
    send_item(make_item(OP_READ_ANT, 0, 0, 0, 0, '0, '0));
    read_cell(10, 10);
    read_cell(ant_px[0], ant_py[0]);
    // Ant on a state beyond the color count stays put
    send_item(make_item(OP_WRITE, 0, ant_px[0], ant_py[0], 200, 24'h123456, '0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, '0, '0));
    send_item(make_item(OP_READ_ANT, 0, 0, 0, 0, '0, '0));
    send_item(make_item(OP_NOP, 5, 1, 2, 3, 24'h010203, 32'h5));
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, '0, '0));
    send_item(make_item(OP_READ_CELL, 0, 255, 255, 0, '0, '0));
    settle();
  endtask

  // Random mix under one setting; ticks dominate so the ants roam
  task automatic test_random_phase(int items);
    int unsigned pick, ai, v;
    logic [31:0] st;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      ai = $urandom_range(0, 7);
      if (pick < 35) begin
        send_item(make_item(OP_TICK, ai, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom, $urandom));
      end else if (pick < 55) begin
        if ($urandom_range(0, 1)) read_cell(ant_px[ai], ant_py[ai]);
        else read_cell($urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 70) begin
        v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 5);
        send_item(make_item(OP_WRITE, ai, $urandom_range(0, 255), $urandom_range(0, 255),
                            v, $urandom, $urandom));
      end else if (pick < 78) begin
        v = $urandom_range(0, 4) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 4);
        st = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
        send_item(make_item(OP_SET_ANT, ai, $urandom_range(0, 255), $urandom_range(0, 255),
                            v, $urandom, st));
      end else if (pick < 90) begin
        send_item(make_item(OP_READ_ANT, ai, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom, $urandom));
      end else if (pick < 97) begin
        v = $urandom_range(0, 4) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 31);
        send_item(make_item(OP_SET_PAL, ai, $urandom_range(0, 255), $urandom_range(0, 255),
                            v, $urandom, $urandom));
      end else begin
        send_item(make_item(OP_NOP, ai, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom, $urandom));
      end
    end
  endtask

  // Long receiver hold while reads keep coming, so the input backs up
  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int n = 0; n < 12; n++)
      send_item(make_item(OP_READ_ANT, n % ANTS, 0, 0, 0, '0, '0));
    settle();
  endtask

  // Receiver stall pattern: a randomly chosen mode, switched at random, or a hold on request
  initial begin
    int mode, left, hold;
    out_stall_i = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 0);
          2:       out_stall_i <= ($urandom_range(0, 9) != 0);
          default: out_stall_i <= ((left % 7) < 3);
        endcase
      end
    end
  end

  // Compare each transferred result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (read_results.size() == 0) begin
        $error("result with no read pending: %h", out_data_o);
        fail_count++;
      end else begin
        want = read_results.pop_front();
        if (out_data_o.red_out !== want.red_out) begin
          $error("red_out expected %0d got %0d", want.red_out, out_data_o.red_out);
          fail_count++;
        end
        if (out_data_o.green_out !== want.green_out) begin
          $error("green_out expected %0d got %0d", want.green_out, out_data_o.green_out);
          fail_count++;
        end
        if (out_data_o.blue_out !== want.blue_out) begin
          $error("blue_out expected %0d got %0d", want.blue_out, out_data_o.blue_out);
          fail_count++;
        end
        if (out_data_o.alpha_out !== want.alpha_out) begin
          $error("alpha_out expected %0d got %0d", want.alpha_out, out_data_o.alpha_out);
          fail_count++;
        end
        if (out_data_o.ant_x !== want.ant_x) begin
          $error("ant_x expected %0d got %0d", want.ant_x, out_data_o.ant_x);
          fail_count++;
        end
        if (out_data_o.ant_y !== want.ant_y) begin
          $error("ant_y expected %0d got %0d", want.ant_y, out_data_o.ant_y);
          fail_count++;
        end
        if (out_data_o.ant_heading !== want.ant_heading) begin
          $error("ant_heading expected %0d got %0d", want.ant_heading,
                 out_data_o.ant_heading);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    fail_count = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    burst_left = 0;
    hold_request = 1'b0;
    for (int c = 0; c < SIDE*SIDE; c++) begin
      grid_state[c] = '0;
      grid_color[c] = '0;
      color_known[c] = 1'b0;
    end
    for (int a = 0; a < ANTS; a++) begin
      ant_px[a] = '0;
      ant_py[a] = '0;
      ant_head[a] = HEAD_N;
      ant_wake[a] = '0;
    end
    foreach (ant_palette[p]) ant_palette[p] = '0;
    tick_total = '0;
    cfg_width = 9'd256;
    cfg_height = 9'd256;
    cfg_colors = 6'd2;
    cfg_rule = 32'd1;
    cfg_ants = 4'd1;
    cfg_marker_en = 1'b1;
    cfg_marker_rgb = '0;
    cfg_opaque = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    no_gaps = 1'b1;
    test_palette_fill();
    no_gaps = 1'b0;
    test_directed();

    write_setting(8, 8, 2, 32'h1, 1, 1'b1, $urandom, 1'b1);
    test_random_phase(PHASE_ITEMS);
    test_backpressure();
    write_setting(1, 511, 32, $urandom, 15, 1'b0, 24'hFFFFFF, 1'b0);
    no_gaps = 1'b1;
    test_random_phase(PHASE_ITEMS);
    no_gaps = 1'b0;
    settle();
    write_setting(0, 1, 0, 32'hFFFF_FFFF, 0, 1'b1, 24'h000000, 1'b1);
    test_random_phase(PHASE_ITEMS / 2);
    settle();
    write_setting(5, 7, 3, $urandom, 3, 1'b1, $urandom, 1'b0);
    test_random_phase(PHASE_ITEMS);
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, '0, '0));
    settle();
    write_setting(16, 3, 63, 32'h0, 8, 1'b1, $urandom, 1'b0);
    test_random_phase(PHASE_ITEMS);
    settle();
    write_setting(256, 256, 6, $urandom, 8, 1'b1, $urandom, 1'b1);
    test_random_phase(PHASE_ITEMS / 2);

    stop_sending();
    wait (read_results.size() == 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### multi_ant_turmite_grid.f
hdl/mat_pkg.sv
hdl/mat_ram.sv
hdl/mat_step.sv
hdl/multi_ant_turmite_grid.sv
bench/tb.sv
